FILE: design/positional_sequence_table_unit_macros.svh
// assertion macros shared by the positional sequence table rtl
`ifndef POSITIONAL_SEQUENCE_TABLE_UNIT_MACROS_SVH
`define POSITIONAL_SEQUENCE_TABLE_UNIT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define PST_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence that must hold in the same cycle as its antecedent
`define PST_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: design/pst_pkg.sv
// shared constants, codes and types of the positional sequence table
`timescale 1ns / 1ps

package pst_pkg;

   // fixed field widths of the request and response beats
   localparam int MODE_W = 3;
   localparam int POS_W  = 9;
   localparam int VAL_W  = 32;
   localparam int IDX_W  = 8;
   localparam int REM_W  = 9;
   localparam int CNTO_W = 9;

   // default sizing
   localparam int CAPACITY_DEF   = 256;
   localparam int ITEM_WIDTH_DEF = 32;

   // request opcodes
   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT  = 3'd0,
      MODE_ORDERED = 3'd1,
      MODE_ERASE   = 3'd2,
      MODE_REMOVE  = 3'd3,
      MODE_GET     = 3'd4,
      MODE_SET     = 3'd5,
      MODE_FIND    = 3'd6
   } pst_mode_type;

   // one response beat
   typedef struct packed {
      logic              ok;
      logic [IDX_W-1:0]  index_out;
      logic [REM_W-1:0]  removed_count;
      logic [VAL_W-1:0]  read_value;
      logic [CNTO_W-1:0] item_count;
   } pst_result_type;

   // status of the shared compare unit
   typedef struct packed {
      logic eq;
      logic le;
   } pst_cmp_type;

endpackage

FILE: design/pst_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface pst_req_if;
   import pst_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [POS_W-1:0]  position;
   logic [VAL_W-1:0]  item_value;

   modport source (output valid, mode, position, item_value, input ready);
   modport sink   (input valid, mode, position, item_value, output ready);
endinterface

interface pst_rsp_if;
   import pst_pkg::*;

   logic              valid;
   logic              ready;
   logic              ok;
   logic [IDX_W-1:0]  index_out;
   logic [REM_W-1:0]  removed_count;
   logic [VAL_W-1:0]  read_value;
   logic [CNTO_W-1:0] item_count;

   modport source (output valid, ok, index_out, removed_count, read_value, item_count,
                   input ready);
   modport sink   (input valid, ok, index_out, removed_count, read_value, item_count,
                   output ready);
endinterface

FILE: design/pst_store.sv
// item storage: one write port, one registered read port
`timescale 1ns / 1ps

module pst_store #(
   parameter int CAPACITY   = pst_pkg::CAPACITY_DEF,
   parameter int ITEM_WIDTH = pst_pkg::ITEM_WIDTH_DEF,
   localparam int AW        = $clog2(CAPACITY)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [ITEM_WIDTH-1:0] wr_data,
   input  logic [AW-1:0]         rd_addr,
   output logic [ITEM_WIDTH-1:0] rd_data
);
   import pst_pkg::*;

   logic [ITEM_WIDTH-1:0] mem [CAPACITY];
   logic [ITEM_WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data registered and valid in the cycle after the address
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/pst_cmp.sv
// shared compare unit: stored item against the request value
`timescale 1ns / 1ps

module pst_cmp #(
   parameter int ITEM_WIDTH = pst_pkg::ITEM_WIDTH_DEF
) (
   input  logic [ITEM_WIDTH-1:0] stored,
   input  logic [ITEM_WIDTH-1:0] value,
   output pst_pkg::pst_cmp_type  cmp
);
   import pst_pkg::*;

   // equality for find and remove, value <= stored for ordered insert
   always_comb begin
      cmp.eq = (stored == value);
      cmp.le = (value <= stored);
   end

endmodule

FILE: design/pst_seq.sv
// sequencer: walks the store one element per cycle for insert, ordered insert, erase, find and remove
`timescale 1ns / 1ps
`include "positional_sequence_table_unit_macros.svh"

module pst_seq #(
   parameter int CAPACITY   = pst_pkg::CAPACITY_DEF,
   parameter int ITEM_WIDTH = pst_pkg::ITEM_WIDTH_DEF,
   localparam int AW        = $clog2(CAPACITY)
) (
   input  logic                    clock,
   input  logic                    reset,
   pst_req_if.sink                 req_chan,
   output logic                    mem_wr_en,
   output logic [AW-1:0]           mem_wr_addr,
   output logic [ITEM_WIDTH-1:0]   mem_wr_data,
   output logic [AW-1:0]           mem_rd_addr,
   input  logic [ITEM_WIDTH-1:0]   mem_rd_data,
   input  pst_pkg::pst_cmp_type    cmp,
   output logic [ITEM_WIDTH-1:0]   cmp_value,
   output logic                    res_valid,
   output pst_pkg::pst_result_type res,
   input  logic                    res_take
);
   import pst_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_SHIFT_UP,
      ST_SHIFT_DN,
      ST_COMPACT,
      ST_GET,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [ITEM_WIDTH-1:0] val_ff, val_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      cur_ff, cur_in;
   logic [CNT_W-1:0]      tgt_ff, tgt_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      didx_ff, didx_in;
   logic                  rv_ff, rv_in;
   pst_result_type        res_ff, res_in;

   logic [CNT_W-1:0] cur_inc, cur_dec, didx_inc, didx_dec, tgt_inc, count_inc, count_dec;
   logic [CMP_W-1:0] pos_cmp, cnt_cmp;
   logic             full, hit, scan_end;

   function automatic pst_result_type make_result(
      input logic              ok,
      input logic [IDX_W-1:0]  idx,
      input logic [REM_W-1:0]  rem,
      input logic [VAL_W-1:0]  rd,
      input logic [CNTO_W-1:0] cnt
   );
      pst_result_type r;
      r.ok            = ok;
      r.index_out     = idx;
      r.removed_count = rem;
      r.read_value    = rd;
      r.item_count    = cnt;
      return r;
   endfunction

   // cursor arithmetic and range checks
   assign cur_inc   = cur_ff + 1'b1;
   assign cur_dec   = cur_ff - 1'b1;
   assign didx_inc  = didx_ff + 1'b1;
   assign didx_dec  = didx_ff - 1'b1;
   assign tgt_inc   = tgt_ff + 1'b1;
   assign count_inc = count_ff + 1'b1;
   assign count_dec = count_ff - 1'b1;
   assign pos_cmp   = CMP_W'(pos_ff);
   assign cnt_cmp   = CMP_W'(count_ff);
   assign full      = (count_ff == CNT_W'(CAPACITY));

   // scan hit: equal for find, first stored item not below the value for ordered insert
   assign hit      = rv_ff && ((mode_ff == MODE_FIND) ? cmp.eq : cmp.le);
   assign scan_end = !rv_ff && (cur_ff == count_ff);

   assign cmp_value      = val_ff;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign res_valid      = (state_ff == ST_DONE);
   assign res            = res_ff;

   // next state, memory port control and result build
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      tgt_in      = tgt_ff;
      rem_in      = rem_ff;
      didx_in     = didx_ff;
      rv_in       = 1'b0;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = tgt_ff[AW-1:0];
      mem_wr_data = val_ff;
      mem_rd_addr = cur_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               mode_in  = req_chan.mode;
               pos_in   = req_chan.position;
               val_in   = ITEM_WIDTH'(req_chan.item_value);
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            unique case (mode_ff)
               MODE_INSERT: begin
                  if (pos_cmp > cnt_cmp || full) begin
                     res_in   = make_result(1'b0, '0, '0, '0, CNTO_W'(count_ff));
                     state_in = ST_DONE;
                  end else begin
                     tgt_in   = CNT_W'(pos_ff);
                     cur_in   = count_ff;
                     state_in = ST_SHIFT_UP;
                  end
               end
               MODE_ORDERED, MODE_FIND: begin
                  cur_in   = '0;
                  state_in = ST_SCAN;
               end
               MODE_ERASE: begin
                  if (pos_cmp >= cnt_cmp) begin
                     res_in   = make_result(1'b0, '0, '0, '0, CNTO_W'(count_ff));
                     state_in = ST_DONE;
                  end else begin
                     cur_in   = CNT_W'(pos_ff) + 1'b1;
                     state_in = ST_SHIFT_DN;
                  end
               end
               MODE_REMOVE: begin
                  cur_in   = '0;
                  tgt_in   = '0;
                  rem_in   = '0;
                  state_in = ST_COMPACT;
               end
               MODE_GET: begin
                  mem_rd_addr = AW'(pos_ff);
                  if (pos_cmp >= cnt_cmp) begin
                     res_in   = make_result(1'b0, '0, '0, '0, CNTO_W'(count_ff));
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_GET;
                  end
               end
               MODE_SET: begin
                  if (pos_cmp >= cnt_cmp) begin
                     res_in = make_result(1'b0, '0, '0, '0, CNTO_W'(count_ff));
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = AW'(pos_ff);
                     mem_wr_data = val_ff;
                     res_in      = make_result(1'b1, '0, '0, '0, CNTO_W'(count_ff));
                  end
                  state_in = ST_DONE;
               end
               default: begin
                  // unused opcode changes nothing
                  res_in   = make_result(1'b0, '0, '0, '0, CNTO_W'(count_ff));
                  state_in = ST_DONE;
               end
            endcase
         end

         // linear search, one read issued per cycle, compare in the cycle after the read
         ST_SCAN: begin
            if (hit || scan_end) begin
               if (mode_ff == MODE_FIND) begin
                  res_in   = make_result(hit, hit ? IDX_W'(didx_ff) : '0, '0, '0,
                                         CNTO_W'(count_ff));
                  state_in = ST_DONE;
               end else if (full) begin
                  res_in   = make_result(1'b0, '0, '0, '0, CNTO_W'(count_ff));
                  state_in = ST_DONE;
               end else begin
                  tgt_in   = hit ? didx_ff : count_ff;
                  cur_in   = count_ff;
                  state_in = ST_SHIFT_UP;
               end
            end else if (cur_ff < count_ff) begin
               rv_in   = 1'b1;
               didx_in = cur_ff;
               cur_in  = cur_inc;
            end
         end

         // open a gap: read entry i-1, write it to i on the next cycle
         ST_SHIFT_UP: begin
            if (rv_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = didx_inc[AW-1:0];
               mem_wr_data = mem_rd_data;
            end
            if (cur_ff > tgt_ff) begin
               mem_rd_addr = cur_dec[AW-1:0];
               rv_in       = 1'b1;
               didx_in     = cur_dec;
               cur_in      = cur_dec;
            end else if (!rv_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = tgt_ff[AW-1:0];
               mem_wr_data = val_ff;
               count_in    = count_inc;
               res_in      = make_result(1'b1, IDX_W'(tgt_ff), '0, '0, CNTO_W'(count_inc));
               state_in    = ST_DONE;
            end
         end

         // close a gap: read entry i, write it to i-1 on the next cycle
         ST_SHIFT_DN: begin
            if (rv_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = didx_dec[AW-1:0];
               mem_wr_data = mem_rd_data;
            end
            if (cur_ff < count_ff) begin
               rv_in   = 1'b1;
               didx_in = cur_ff;
               cur_in  = cur_inc;
            end else if (!rv_ff) begin
               count_in = count_dec;
               res_in   = make_result(1'b1, '0, '0, '0, CNTO_W'(count_dec));
               state_in = ST_DONE;
            end
         end

         // compaction: matches are counted, the rest move down to the keep index
         ST_COMPACT: begin
            if (rv_ff) begin
               if (cmp.eq) begin
                  rem_in = rem_ff + 1'b1;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = tgt_ff[AW-1:0];
                  mem_wr_data = mem_rd_data;
                  tgt_in      = tgt_inc;
               end
            end
            if (cur_ff < count_ff) begin
               rv_in   = 1'b1;
               didx_in = cur_ff;
               cur_in  = cur_inc;
            end else if (!rv_ff) begin
               count_in = tgt_ff;
               res_in   = make_result(1'b1, '0, REM_W'(rem_ff), '0, CNTO_W'(tgt_ff));
               state_in = ST_DONE;
            end
         end

         ST_GET: begin
            res_in   = make_result(1'b1, '0, '0, VAL_W'(mem_rd_data), CNTO_W'(count_ff));
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      mode_ff <= mode_in;
      pos_ff  <= pos_in;
      val_ff  <= val_in;
      cur_ff  <= cur_in;
      tgt_ff  <= tgt_in;
      rem_ff  <= rem_in;
      didx_ff <= didx_in;
      res_ff  <= res_in;
   end

   // checks
   `PST_ASSERT_ALWAYS(a_count_in_range, clock, reset, count_ff <= CNT_W'(CAPACITY), "fill count above capacity")
   `PST_ASSERT_IMPLY(a_keep_behind_read, clock, reset, state_ff == ST_COMPACT, tgt_ff <= cur_ff, "compaction overtook the read cursor")
   `PST_ASSERT_IMPLY(a_shift_above_gap, clock, reset, state_ff == ST_SHIFT_UP, cur_ff >= tgt_ff, "shift cursor passed the insert point")
   `PST_ASSERT_IMPLY(a_result_count, clock, reset, state_ff == ST_DONE, res_ff.item_count == CNTO_W'(count_ff), "result count differs from fill count")

endmodule

FILE: design/positional_sequence_table_unit.sv
// top level of the positional sequence table
//
//  channel    direction  beat contents
//  req_chan   in         mode, position, item_value
//  rsp_chan   out        ok, index_out, removed_count, read_value, item_count
//
// one request at a time; set and rejects complete from dispatch, get adds a read of the
// store, erase, insert, find and remove-all walk the stored items, and ordered insert
// walks twice (scan, then shift), so the time to a response grows with the fill count.
// the walks run one element per cycle through the single write and read ports
// of the item store. reset clears the fill count, the state and the response valid; the store is not swept.
// a pending response beat stalls completion of the next request, not its accept.
`timescale 1ns / 1ps

module positional_sequence_table_unit #(
   parameter int CAPACITY   = pst_pkg::CAPACITY_DEF,
   parameter int ITEM_WIDTH = pst_pkg::ITEM_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   pst_req_if.sink   req_chan,
   pst_rsp_if.source rsp_chan
);
   import pst_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [ITEM_WIDTH-1:0] mem_wr_data;
   logic [AW-1:0]         mem_rd_addr;
   logic [ITEM_WIDTH-1:0] mem_rd_data;
   logic [ITEM_WIDTH-1:0] cmp_value;
   pst_cmp_type           cmp;
   logic                  res_valid;
   pst_result_type        res;
   logic                  res_take;
   logic                  slot_free;
   logic                  rsp_valid_ff, rsp_valid_in;
   pst_result_type        rsp_data_ff;

   pst_store #(
      .CAPACITY   (CAPACITY),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pst_cmp #(
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_cmp (
      .stored (mem_rd_data),
      .value  (cmp_value),
      .cmp    (cmp)
   );

   pst_seq #(
      .CAPACITY   (CAPACITY),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .cmp         (cmp),
      .cmp_value   (cmp_value),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (res_take)
   );

   // response register: takes a result whenever the slot is empty or draining
   assign slot_free    = !rsp_valid_ff || rsp_chan.ready;
   assign res_take     = res_valid && slot_free;
   assign rsp_valid_in = res_take ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_take) begin
         rsp_data_ff <= res;
      end
   end

   // response beat
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.ok            = rsp_data_ff.ok;
   assign rsp_chan.index_out     = rsp_data_ff.index_out;
   assign rsp_chan.removed_count = rsp_data_ff.removed_count;
   assign rsp_chan.read_value    = rsp_data_ff.read_value;
   assign rsp_chan.item_count    = rsp_data_ff.item_count;

endmodule
